// File: rtl/ttss_pkg.sv
// Package for the triplet seed selection block: payload structs, sizes, codes.
// No dependencies.
package ttss_pkg;

  localparam int MaxHits = 32;
  localparam int IdxW = $clog2(MaxHits);
  localparam int CntW = $clog2(MaxHits + 1);
  localparam int HitW = 73;

  localparam logic [1:0] StFound = 2'd0;
  localparam logic [1:0] StFewMeas = 2'd1;
  localparam logic [1:0] StFewPts = 2'd2;
  localparam logic [1:0] StNoTriplet = 2'd3;

  localparam logic [1:0] RegRMin = 2'd0;
  localparam logic [1:0] RegRMax = 2'd1;
  localparam logic [1:0] RegZMin = 2'd2;
  localparam logic [1:0] RegZMax = 2'd3;

  typedef struct packed {
    logic [31:0] hit_time;
    logic        has_point;
    logic [19:0] radius;
    logic signed [19:0] z_pos;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  bottom_pos;
    logic [4:0]  middle_pos;
    logic [4:0]  top_pos;
    logic [39:0] best_score;
    logic        overflowed;
  } out_item_t;

  typedef struct packed {
    logic [31:0] t;
    logic        p;
    logic [19:0] r;
    logic [19:0] z;
  } hit_t;

  typedef struct packed {
    logic [19:0] rmin;
    logic [19:0] rmax;
    logic [19:0] zmin;
    logic [19:0] zmax;
  } win_t;

endpackage

// File: rtl/track_triplet_seed_select_unit.sv
// Top level of the triplet seed selection block: registers and sequencer.
// Depends on ttss_pkg and ttss_ctrl.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | in_item_t
//  out     | output    | out_valid/out_stall | out_item_t
//  cfg     | input     | cfg_we            | cfg_index, cfg_data
//
// Loading takes one cycle per item. On the last item the block sorts the
// hits by time (insertion sort: S_SRD, S_SKEY and S_SCMP per hit, S_SCMP
// again per shift), builds the point list (S_PTS and S_PTSW per hit) and
// searches triplets, reading each visited bottom, middle and top point and
// scoring each valid triplet in S_MUL; all through one RAM read port. S_EVAL
// checks the counts and S_OUT decides the status and registers the result.
// Reset is synchronous; it clears the item count and the overflow and valid
// flags and sets the windows to their widest range. in_stall stays high from
// the last item until the result is registered; a waiting result stalls only the next track's S_OUT.
module track_triplet_seed_select_unit import ttss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  win_t win;

  // hold the search windows; write one per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '{rmin: '0, rmax: '1, zmin: '0, zmax: '1};
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRMin: win.rmin <= cfg_data;
        RegRMax: win.rmax <= cfg_data;
        RegZMin: win.zmin <= cfg_data;
        RegZMax: win.zmax <= cfg_data;
        default: ;
      endcase
    end
  end

  ttss_ctrl u_ctrl (.clk, .rst, .in_valid, .in_stall, .in_data,
                    .out_valid, .out_stall, .out_data, .win);
endmodule

// File: rtl/ttss_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ttss_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/ttss_pair.sv
// Pair window check between an inner and an outer space point.
// Depends on ttss_pkg.
module ttss_pair import ttss_pkg::*; (
  input  hit_t        a,
  input  hit_t        b,
  input  win_t        win,
  output logic        ok,
  output logic [19:0] dr
);
  logic signed [20:0] d;
  logic signed [20:0] dz;
  logic [20:0] adz;
  always_comb begin
    d   = $signed({1'b0, b.r}) - $signed({1'b0, a.r});
    dz  = $signed({b.z[19], b.z}) - $signed({a.z[19], a.z});
    adz = dz[20] ? 21'(-dz) : 21'(dz);
    dr  = d[19:0];
    ok  = !d[20] && (d[19:0] >= win.rmin) && (d[19:0] <= win.rmax)
          && (adz >= {1'b0, win.zmin}) && (adz <= {1'b0, win.zmax});
  end
endmodule

// File: rtl/ttss_ctrl.sv
// Sequencer: load, stable time sort, point list build and triplet search.
// Depends on ttss_pkg, ttss_ram, ttss_pair.
module ttss_ctrl import ttss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  win_t      win
);
  typedef enum logic [3:0] {
    S_LOAD, S_SRD, S_SKEY, S_SCMP, S_PTS, S_PTSW, S_EVAL,
    S_RB, S_RBW, S_RM, S_RMW, S_RT, S_RTW, S_MUL, S_OUT
  } state_t;
  state_t state;

  logic [CntW-1:0] cnt, i, j, b, m, t, np;
  logic ovf;
  logic [IdxW-1:0] ord [MaxHits];
  logic [IdxW-1:0] pts [MaxHits];
  logic [31:0] key;
  hit_t hb, hm;
  logic [19:0] d1, d2;
  logic [39:0] best, prod;
  logic found;
  logic [IdxW-1:0] bb, bm, bt;

  logic ram_we;
  logic [IdxW-1:0] ram_raddr;
  hit_t ram_rd, wr_hit;
  logic acc;

  // a finished result waits in the output register; loading of the next track goes on
  assign in_stall = (state != S_LOAD);
  assign acc = in_valid && !in_stall;
  assign wr_hit = '{t: in_data.hit_time, p: in_data.has_point,
                    r: in_data.radius, z: in_data.z_pos};
  assign ram_we = acc && (cnt < CntW'(MaxHits));

  // S_SCMP reads one entry ahead, so the next compare finds its data ready
  always_comb begin
    ram_raddr = '0;
    unique case (state)
      S_SRD:         ram_raddr = i[IdxW-1:0];
      S_SKEY:        ram_raddr = ord[j[IdxW-1:0] - 1'b1];
      S_SCMP:        ram_raddr = ord[j[IdxW-1:0] - 2'd2];
      S_PTS, S_PTSW: ram_raddr = ord[i[IdxW-1:0]];
      S_RB, S_RBW:   ram_raddr = pts[b[IdxW-1:0]];
      S_RM, S_RMW:   ram_raddr = pts[m[IdxW-1:0]];
      S_RT, S_RTW:   ram_raddr = pts[t[IdxW-1:0]];
      default:       ram_raddr = '0;
    endcase
  end

  ttss_ram #(.Width(HitW), .Depth(MaxHits)) u_ram (
    .clk, .we(ram_we), .waddr(cnt[IdxW-1:0]), .wdata(wr_hit),
    .raddr(ram_raddr), .rdata(ram_rd));

  logic ok_bm, ok_mt;
  logic [19:0] dr_bm, dr_mt;
  ttss_pair u_p1 (.a(hb), .b(ram_rd), .win, .ok(ok_bm), .dr(dr_bm));
  ttss_pair u_p2 (.a(hm), .b(ram_rd), .win, .ok(ok_mt), .dr(dr_mt));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD; cnt <= '0; ovf <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_LOAD: if (acc) begin
          if (!ram_we) ovf <= 1'b1;
          if (ram_we) cnt <= cnt + 1'b1;
          if (in_data.last) begin
            i <= '0; state <= S_SRD;
          end
        end
        // insertion sort: read key of item i, then walk j down
        S_SRD: if (i == cnt) begin
          i <= '0; np <= '0; state <= S_PTS;
        end else begin
          j <= i; state <= S_SKEY;
        end
        S_SKEY: begin
          key <= ram_rd.t; state <= S_SCMP;
        end
        S_SCMP: begin
          if (j == '0) begin
            ord[0] <= i[IdxW-1:0]; i <= i + 1'b1; state <= S_SRD;
          end else if (ram_rd.t > key) begin
            ord[j[IdxW-1:0]] <= ord[j[IdxW-1:0] - 1'b1]; j <= j - 1'b1;
          end else begin
            ord[j[IdxW-1:0]] <= i[IdxW-1:0]; i <= i + 1'b1; state <= S_SRD;
          end
        end
        S_PTS: if (i == cnt) begin
          found <= 1'b0; best <= '0; b <= '0; state <= S_EVAL;
        end else state <= S_PTSW;
        S_PTSW: begin
          if (ram_rd.p) begin pts[np[IdxW-1:0]] <= ord[i[IdxW-1:0]]; np <= np + 1'b1; end
          i <= i + 1'b1; state <= S_PTS;
        end
        S_EVAL: begin
          if (cnt < CntW'(3) || np < CntW'(3)) state <= S_OUT;
          else state <= S_RB;
        end
        S_RB: if (b + CntW'(2) >= np) state <= S_OUT; else state <= S_RBW;
        S_RBW: begin hb <= ram_rd; m <= b + 1'b1; state <= S_RM; end
        S_RM: if (m + CntW'(1) >= np) begin b <= b + 1'b1; state <= S_RB; end
              else state <= S_RMW;
        S_RMW: begin
          hm <= ram_rd; d1 <= dr_bm;
          if (ok_bm) begin t <= m + 1'b1; state <= S_RT; end
          else begin m <= m + 1'b1; state <= S_RM; end
        end
        S_RT: if (t >= np) begin m <= m + 1'b1; state <= S_RM; end
              else state <= S_RTW;
        S_RTW: begin
          if (ok_mt) begin d2 <= dr_mt; state <= S_MUL; end
          else begin t <= t + 1'b1; state <= S_RT; end
        end
        S_MUL: begin
          if (prod > best) begin
            best <= prod; found <= 1'b1;
            bb <= pts[b[IdxW-1:0]]; bm <= pts[m[IdxW-1:0]]; bt <= pts[t[IdxW-1:0]];
          end
          t <= t + 1'b1; state <= S_RT;
        end
        // hold here while the previous result still waits at the output
        S_OUT: if (!out_valid) begin
          out_valid <= 1'b1;
          out_data.status <= (cnt < CntW'(3)) ? StFewMeas :
                             (np < CntW'(3)) ? StFewPts :
                             found ? StFound : StNoTriplet;
          out_data.bottom_pos <= found ? 5'(bb) : '0;
          out_data.middle_pos <= found ? 5'(bm) : '0;
          out_data.top_pos    <= found ? 5'(bt) : '0;
          out_data.best_score <= found ? best : '0;
          out_data.overflowed <= ovf;
          cnt <= '0; ovf <= 1'b0; state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
      if (state == S_EVAL) found <= 1'b0;
    end
  end

  assign prod = 40'(d1) * 40'(d2);
endmodule

// File: rtl/ttss_checker.sv
// Port-level checks for the triplet seed selection block, bound to the top.
// Depends on ttss_pkg.
module ttss_checker import ttss_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_no_seed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != StFound |-> out_data.best_score == '0)
    else $error("score without seed");
  a_seed_score: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == StFound |-> out_data.best_score != '0)
    else $error("seed with zero score");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.last |=> in_stall)
    else $error("input taken during evaluation");
endmodule

bind track_triplet_seed_select_unit ttss_checker u_chk (.*);
